### src/snv_pkg.sv
// Shared types and constants for the surface nets cell vertex block.
`default_nettype none
package snv_pkg;

  localparam int MASK_W  = 8;
  localparam int COORD_W = 7;
  localparam int IDX_W   = 17;
  localparam int EDGE_W  = 4;
  localparam int HALF_W  = 5;
  localparam int POS_W   = 17;

  localparam logic [MASK_W-1:0] ALL_EMPTY = 8'h00;
  localparam logic [MASK_W-1:0] ALL_SOLID = 8'hFF;

  localparam logic [POS_W-1:0] POS_MAX = 17'h0FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 17'h10000;

  typedef struct packed {
    logic load;
    logic step;
    logic xfer;
  } snv_cmd_t;

endpackage
`default_nettype wire

### src/snv_div.sv
// Restoring divider that produces one quotient bit per step.
`default_nettype none
module snv_div #(
  parameter int NW = 15,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          step,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo
);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (load) begin
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
    end else if (step) begin
      rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo_nxt = {quo_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

### src/snv_ctrl.sv
// Controller that sequences the load, the division steps and the output transfer.
`default_nettype none
module snv_ctrl
  import snv_pkg::*;
#(
  parameter int STEPS = 15
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output snv_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;
  localparam int   CNT_W   = $clog2(STEPS + 1);

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(STEPS);
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (cnt_r != '0) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
        end else if (!out_valid_r || !out_stall) begin
          cmd.xfer      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### src/snv_dp.sv
// Datapath with edge analysis, vertex counter, three dividers and output registers.
`default_nettype none
module snv_dp
  import snv_pkg::*;
#(
  parameter int FRAC_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire snv_cmd_t                    cmd,
  input  wire logic        [MASK_W-1:0]    in_corner_bits,
  input  wire logic signed [COORD_W-1:0]   in_cell_x,
  input  wire logic signed [COORD_W-1:0]   in_cell_y,
  input  wire logic signed [COORD_W-1:0]   in_cell_z,
  input  wire logic                        in_first_cell,
  output logic                             out_has_vertex,
  output logic             [IDX_W-1:0]     out_vertex_index,
  output logic             [EDGE_W-1:0]    out_crossing_edges,
  output logic signed      [POS_W-1:0]     out_pos_x,
  output logic signed      [POS_W-1:0]     out_pos_y,
  output logic signed      [POS_W-1:0]     out_pos_z
);

  localparam int NW = HALF_W + FRAC_BITS;
  localparam int DW = HALF_W;
  localparam int OW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 14;

  logic [EDGE_W-1:0] n_c;
  logic [HALF_W-1:0] hx_c, hy_c, hz_c;
  logic              has_c;
  logic [IDX_W-1:0]  idx_c;

  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              has_r;
  logic [IDX_W-1:0]  idx_r;
  logic [EDGE_W-1:0] n_r;
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;

  logic [NW-1:0] qx, qy, qz;
  logic [DW-1:0] den_c;

  always_comb begin
    logic [2:0] kv;
    logic [2:0] jv;
    n_c  = '0;
    hx_c = '0;
    hy_c = '0;
    hz_c = '0;
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++) begin
        kv = 3'(k);
        jv = kv | (3'd1 << a);
        if (!kv[a] && (in_corner_bits[kv] != in_corner_bits[jv])) begin
          n_c  = n_c + 1'b1;
          hx_c = hx_c + HALF_W'(kv[0]) + HALF_W'(jv[0]);
          hy_c = hy_c + HALF_W'(kv[1]) + HALF_W'(jv[1]);
          hz_c = hz_c + HALF_W'(kv[2]) + HALF_W'(jv[2]);
        end
      end
    end
  end

  assign has_c = (in_corner_bits != ALL_EMPTY) && (in_corner_bits != ALL_SOLID);
  assign idx_c = in_first_cell ? '0 : cnt_r;
  assign den_c = {n_c, 1'b0};

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = has_c ? idx_c + 1'b1 : idx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      has_r <= has_c;
      idx_r <= idx_c;
      n_r   <= n_c;
      cx_r  <= in_cell_x;
      cy_r  <= in_cell_y;
      cz_r  <= in_cell_z;
    end
  end

  snv_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .num({hx_c, FRAC_BITS'(n_c)}), .den(den_c), .quo(qx)
  );

  snv_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .num({hy_c, FRAC_BITS'(n_c)}), .den(den_c), .quo(qy)
  );

  snv_div #(.NW(NW), .DW(DW)) u_div_z (
    .clk(clk), .load(cmd.load), .step(cmd.step),
    .num({hz_c, FRAC_BITS'(n_c)}), .den(den_c), .quo(qz)
  );

  function automatic logic [POS_W-1:0] place(input logic [COORD_W-1:0] c,
                                             input logic [OW-1:0] off);
    logic [PW-1:0] p;
    logic          fits;
    p    = ({{(PW-COORD_W){c[COORD_W-1]}}, c} << FRAC_BITS) + PW'(off);
    fits = (&p[PW-1:POS_W-1]) || !(|p[PW-1:POS_W-1]);
    if (fits) begin
      place = p[POS_W-1:0];
    end else begin
      place = p[PW-1] ? POS_MIN : POS_MAX;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.xfer) begin
      out_has_vertex     <= has_r;
      out_vertex_index   <= has_r ? idx_r : '0;
      out_crossing_edges <= has_r ? n_r : '0;
      out_pos_x          <= has_r ? place(cx_r, qx[OW-1:0]) : '0;
      out_pos_y          <= has_r ? place(cy_r, qy[OW-1:0]) : '0;
      out_pos_z          <= has_r ? place(cz_r, qz[OW-1:0]) : '0;
    end
  end

endmodule
`default_nettype wire

### src/surface_nets_cell_vertex.sv
// Top level of the surface nets cell vertex block.
// Each beat carries one grid cell; the block returns one result beat per cell
// holding the vertex flag, the vertex index, the crossing edge count and the
// vertex position in units of 2^-FRAC_BITS, saturated to 17 bits signed. A cell
// passes through a load, FRAC_BITS + 5 steps of the bit-serial dividers that
// form the mean edge offset, and a transfer into the output register, which
// waits while a held result is stalled. The next cell is accepted once the
// previous result has been transferred, even while that result still waits in
// the output register.
`default_nettype none
module surface_nets_cell_vertex
  import snv_pkg::*;
#(
  parameter int FRAC_BITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic        [MASK_W-1:0]  in_corner_bits,
  input  wire logic signed [COORD_W-1:0] in_cell_x,
  input  wire logic signed [COORD_W-1:0] in_cell_y,
  input  wire logic signed [COORD_W-1:0] in_cell_z,
  input  wire logic                      in_first_cell,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_has_vertex,
  output logic             [IDX_W-1:0]   out_vertex_index,
  output logic             [EDGE_W-1:0]  out_crossing_edges,
  output logic signed      [POS_W-1:0]   out_pos_x,
  output logic signed      [POS_W-1:0]   out_pos_y,
  output logic signed      [POS_W-1:0]   out_pos_z
);

  snv_cmd_t cmd;

  snv_ctrl #(.STEPS(HALF_W + FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  snv_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_corner_bits    (in_corner_bits),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_cell_z         (in_cell_z),
    .in_first_cell     (in_first_cell),
    .out_has_vertex    (out_has_vertex),
    .out_vertex_index  (out_vertex_index),
    .out_crossing_edges(out_crossing_edges),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side not busy after an accepted beat");

  a_empty_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_vertex) |->
      (out_vertex_index == '0 && out_crossing_edges == '0 &&
       out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0))
    else $error("cell without vertex has nonzero result fields");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_vertex) |->
      (out_crossing_edges >= 4'd3 && out_crossing_edges <= 4'd12))
    else $error("crossing edge count out of range for a surface cell");
`endif

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the surface nets cell vertex block.
`default_nettype none
module testbench
  import snv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_CELLS = 1630;
  localparam int SETTLE_CYCLES = 2 * (FRAC + 7);

  typedef struct packed {
    logic        [MASK_W-1:0]  corners;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      first;
    logic                      drain;
  } grid_cell_t;

  typedef struct packed {
    logic                    has;
    logic        [IDX_W-1:0]  idx;
    logic        [EDGE_W-1:0] edges;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  pz;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic        [MASK_W-1:0]  in_corner_bits = '0;
  logic signed [COORD_W-1:0] in_cell_x = '0;
  logic signed [COORD_W-1:0] in_cell_y = '0;
  logic signed [COORD_W-1:0] in_cell_z = '0;
  logic                      in_first_cell = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_has_vertex;
  logic        [IDX_W-1:0]   out_vertex_index;
  logic        [EDGE_W-1:0]  out_crossing_edges;
  logic signed [POS_W-1:0]   out_pos_x;
  logic signed [POS_W-1:0]   out_pos_y;
  logic signed [POS_W-1:0]   out_pos_z;

  grid_cell_t pending_cells[$];
  vertex_t    expected_vertices[$];
  grid_cell_t current_cell = '0;
  logic [IDX_W-1:0] vertex_counter = '0;
  int mismatches = 0;
  int idle_cycles = 0;
  int cycle_no = 0;
  logic calm;

  surface_nets_cell_vertex #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_corner_bits(in_corner_bits),
    .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y),
    .in_cell_z(in_cell_z),
    .in_first_cell(in_first_cell),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_has_vertex(out_has_vertex),
    .out_vertex_index(out_vertex_index),
    .out_crossing_edges(out_crossing_edges),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z)
  );

  always #10 clk = ~clk;

  assign calm = (cycle_no >= 9000) && (cycle_no < 13000);

  function automatic logic signed [POS_W-1:0] place_axis(logic signed [COORD_W-1:0] c,
                                                          int halves, int n);
    int base;
    int off;
    int p;
    base = int'(c);
    off = (halves * (1 << FRAC) + n) / (2 * n);
    p = base * (1 << FRAC) + off;
    if (p > 65535) p = 65535;
    if (p < -65536) p = -65536;
    return p[POS_W-1:0];
  endfunction

  function automatic vertex_t place_vertex(grid_cell_t c);
    vertex_t v;
    int hx;
    int hy;
    int hz;
    int n;
    int k;
    int b;
    int j;
    v = '0;
    hx = 0;
    hy = 0;
    hz = 0;
    n = 0;
    if (c.first) vertex_counter = '0;
    if (c.corners == ALL_EMPTY || c.corners == ALL_SOLID) return v;
    for (k = 0; k < 8; k++) begin
      for (b = 1; b < 8; b = b << 1) begin
        j = k | b;
        if (j != k && c.corners[k] != c.corners[j]) begin
          hx += (k & 1) + (j & 1);
          hy += ((k >> 1) & 1) + ((j >> 1) & 1);
          hz += ((k >> 2) & 1) + ((j >> 2) & 1);
          n++;
        end
      end
    end
    v.has = 1'b1;
    v.idx = vertex_counter;
    v.edges = n[EDGE_W-1:0];
    v.px = place_axis(c.x, hx, n);
    v.py = place_axis(c.y, hy, n);
    v.pz = place_axis(c.z, hz, n);
    vertex_counter = vertex_counter + 1'b1;
    return v;
  endfunction

  task automatic add_cell(logic [MASK_W-1:0] corners, int x, int y, int z,
                          logic first, logic drain);
    grid_cell_t c;
    c.corners = corners;
    c.x = x[COORD_W-1:0];
    c.y = y[COORD_W-1:0];
    c.z = z[COORD_W-1:0];
    c.first = first;
    c.drain = drain;
    pending_cells.insert(pending_cells.size(), c);
  endtask

  function automatic int random_coord();
    if ($urandom_range(9) == 0) return $urandom_range(127);
    return int'($urandom_range(79)) - 16;
  endfunction

  function automatic logic [MASK_W-1:0] random_corners();
    int r;
    r = $urandom_range(99);
    if (r < 4) return ALL_EMPTY;
    if (r < 8) return ALL_SOLID;
    return MASK_W'($urandom_range(255));
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on %s at %0t: expected %0d, got %0d", name, $realtime, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_vertices.insert(expected_vertices.size(), place_vertex(current_cell));
      if (!in_valid || !in_stall) begin
        if (pending_cells.size() > 0 && !(!calm && $urandom_range(99) < 7) &&
            !(pending_cells[0].drain && expected_vertices.size() > 0)) begin
          current_cell = pending_cells.pop_front();
          in_corner_bits <= current_cell.corners;
          in_cell_x <= current_cell.x;
          in_cell_y <= current_cell.y;
          in_cell_z <= current_cell.z;
          in_first_cell <= current_cell.first;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat at %0t", $realtime);
        end else begin
          vertex_t want;
          want = expected_vertices.pop_front();
          compare_field("has_vertex", longint'(want.has), longint'(out_has_vertex));
          compare_field("vertex_index", longint'(want.idx), longint'(out_vertex_index));
          compare_field("crossing_edges", longint'(want.edges),
                        longint'(out_crossing_edges));
          compare_field("pos_x", longint'(want.px), longint'(out_pos_x));
          compare_field("pos_y", longint'(want.py), longint'(out_pos_y));
          compare_field("pos_z", longint'(want.pz), longint'(out_pos_z));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    add_cell(8'h00, 0, 0, 0, 1'b1, 1'b0);
    add_cell(8'hFF, 63, 63, 63, 1'b0, 1'b0);
    add_cell(8'h01, -64, -64, -64, 1'b1, 1'b0);
    add_cell(8'h80, 63, 63, 63, 1'b0, 1'b0);
    add_cell(8'hFE, -1, 0, 1, 1'b0, 1'b0);
    add_cell(8'h7F, 63, -64, 0, 1'b0, 1'b0);
    add_cell(8'h0F, -16, 31, 62, 1'b0, 1'b0);
    add_cell(8'h33, 5, -5, 17, 1'b0, 1'b0);
    add_cell(8'h55, 0, 63, -64, 1'b0, 1'b0);
    add_cell(8'h69, 63, 63, 63, 1'b0, 1'b0);
    add_cell(8'h96, -64, -64, -64, 1'b0, 1'b0);
    add_cell(8'h81, 10, 20, 30, 1'b0, 1'b0);
    add_cell(8'h00, 1, 2, 3, 1'b1, 1'b0);
    add_cell(8'h01, 63, 0, -1, 1'b0, 1'b0);
    add_cell(8'hAA, -1, 0, 1, 1'b0, 1'b0);
    add_cell(8'h3C, 42, -42, 21, 1'b0, 1'b0);
    add_cell(8'hC3, -33, 33, -7, 1'b0, 1'b0);
    add_cell(8'hFF, -64, -64, -64, 1'b1, 1'b0);
    add_cell(8'h02, 63, 63, 63, 1'b0, 1'b0);
    add_cell(8'hF0, -16, -16, -16, 1'b0, 1'b0);
    for (int i = 0; i < RANDOM_CELLS; i++)
      add_cell(random_corners(), random_coord(), random_coord(), random_coord(),
               $urandom_range(99) < 3, i == 400 || i == 1200);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cells.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
